>>> design/dts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg
// Shared codes, command and status bundles for the dependency task scheduler.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam logic [2:0] ACT_ADD      = 3'd0;
  localparam logic [2:0] ACT_DEPEND   = 3'd1;
  localparam logic [2:0] ACT_QUEUE    = 3'd2;
  localparam logic [2:0] ACT_FETCH    = 3'd3;
  localparam logic [2:0] ACT_COMPLETE = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_QFULL   = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  typedef enum logic [1:0] {KEY_REL, KEY_TGT, KEY_DEP, KEY_PAR} key_sel_t;
  typedef enum logic [1:0] {SA_SCAN, SA_SEL, SA_ENT, SA_QDATA} slot_addr_t;
  typedef enum logic [1:0] {PEND_NONE, PEND_INC, PEND_DEC} pend_op_t;
  typedef enum logic [1:0] {RES_EMPTY, RES_NEWID, RES_FETCH} res_kind_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_A_FP, S_A_PRD, S_A_PINC, S_A_FREE, S_A_ALLOC,
    S_T_FIND, S_D_WR, S_Q_WR,
    S_C_RD, S_C_WR, S_C_FP, S_C_PRD, S_C_PDEC,
    S_F_Q, S_F_E, S_F_CHK, S_F_DEP, S_F_R, S_F_RES, S_F_SH, S_F_SHW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       cap;
    logic       key_ld;
    key_sel_t   key_sel;
    logic       scan_start;
    logic       scan_step;
    logic       scan_free;
    slot_addr_t slot_addr;
    logic       set_sel;
    pend_op_t   pend_op;
    logic       alloc;
    logic       kill;
    logic       dep_wr;
    logic       q_push;
    logic       q_rd_next;
    logic       q_wr;
    logic       qptr_clr;
    logic       qptr_inc;
    logic       q_dec;
    logic       ent_ld;
    logic       res_ld;
    res_kind_t  res_kind;
    logic [2:0] res_status;
    logic       out_ld;
  } dts_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       hit;
    logic       miss;
    logic       key_neg;
    logic       pend_one;
    logic       q_more;
    logic       q_next_more;
    logic       q_full;
    logic       out_free;
  } dts_stat_t;

endpackage

>>> design/dependency_task_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_task_scheduler_core
// Task table with parent counts, dependencies and a FIFO ready queue.
// ----------------------------------------------------------------------------
// One beat at a time; each ID lookup scans the slot table at one slot a cycle.
// Fetch walks the queue from its head, takes the first entry that is ready and
// closes the gap by moving each later entry forward one place.
// Reset clears live bits, pending counts, queue count and the ID counter.
module dependency_task_scheduler_core #(
  parameter int TASK_SLOTS  = 64,
  parameter int ID_LIMIT    = 65535,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // target_id[16:0], related_id[33:17], work_handle[65:34]
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // result_id[16:0], result_work[48:17]
  output logic [2:0]  m_tuser    // status[2:0]
);
  import dts_pkg::*;

  dts_cmd_t  cmd;
  dts_stat_t stat;

  dts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dts_dp #(
    .TASK_SLOTS  (TASK_SLOTS),
    .ID_LIMIT    (ID_LIMIT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

>>> design/dts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_ctrl
// Sequencer that steps the datapath through the scans of each action.
// ----------------------------------------------------------------------------
module dts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  dts_pkg::dts_stat_t stat,
  output dts_pkg::dts_cmd_t  cmd
);
  import dts_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.key_sel = KEY_REL;
    cmd.slot_addr = SA_SCAN;
    cmd.pend_op = PEND_NONE;
    cmd.res_kind = RES_EMPTY;
    cmd.res_status = ST_OK;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.cap = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.act)
          ACT_ADD: begin
            cmd.key_ld = 1'b1;
            cmd.key_sel = KEY_REL;
            cmd.scan_start = 1'b1;
            state_next = S_A_FP;
          end
          ACT_DEPEND, ACT_QUEUE, ACT_COMPLETE: begin
            cmd.key_ld = 1'b1;
            cmd.key_sel = KEY_TGT;
            cmd.scan_start = 1'b1;
            state_next = S_T_FIND;
          end
          ACT_FETCH: begin
            cmd.qptr_clr = 1'b1;
            state_next = S_F_Q;
          end
          default: begin
            cmd.res_ld = 1'b1;
            state_next = S_FIN;
          end
        endcase
      end
      // raise the parent's count before looking for a free slot
      S_A_FP: begin
        cmd.scan_step = 1'b1;
        if (stat.key_neg || stat.miss) begin
          cmd.scan_start = 1'b1;
          state_next = S_A_FREE;
        end else if (stat.hit) begin
          cmd.set_sel = 1'b1;
          state_next = S_A_PRD;
        end
      end
      S_A_PRD: begin
        cmd.slot_addr = SA_SEL;
        state_next = S_A_PINC;
      end
      S_A_PINC: begin
        cmd.pend_op = PEND_INC;
        cmd.scan_start = 1'b1;
        state_next = S_A_FREE;
      end
      S_A_FREE: begin
        cmd.scan_step = 1'b1;
        cmd.scan_free = 1'b1;
        if (stat.hit) begin
          cmd.set_sel = 1'b1;
          state_next = S_A_ALLOC;
        end else if (stat.miss) begin
          cmd.res_ld = 1'b1;
          cmd.res_status = ST_FULL;
          state_next = S_FIN;
        end
      end
      S_A_ALLOC: begin
        cmd.alloc = 1'b1;
        cmd.res_ld = 1'b1;
        cmd.res_kind = RES_NEWID;
        state_next = S_FIN;
      end
      S_T_FIND: begin
        cmd.scan_step = 1'b1;
        if (stat.key_neg || stat.miss) begin
          cmd.res_ld = 1'b1;
          cmd.res_status = ST_UNKNOWN;
          state_next = S_FIN;
        end else if (stat.hit) begin
          cmd.set_sel = 1'b1;
          case (stat.act)
            ACT_DEPEND: state_next = S_D_WR;
            ACT_QUEUE:  state_next = S_Q_WR;
            default:    state_next = S_C_RD;
          endcase
        end
      end
      S_D_WR: begin
        cmd.dep_wr = 1'b1;
        cmd.res_ld = 1'b1;
        state_next = S_FIN;
      end
      S_Q_WR: begin
        cmd.res_ld = 1'b1;
        if (stat.q_full) begin
          cmd.res_status = ST_QFULL;
        end else begin
          cmd.q_push = 1'b1;
        end
        state_next = S_FIN;
      end
      S_C_RD: begin
        cmd.slot_addr = SA_SEL;
        state_next = S_C_WR;
      end
      S_C_WR: begin
        cmd.pend_op = PEND_DEC;
        cmd.kill = 1'b1;
        cmd.key_ld = 1'b1;
        cmd.key_sel = KEY_PAR;
        cmd.scan_start = 1'b1;
        state_next = S_C_FP;
      end
      S_C_FP: begin
        cmd.scan_step = 1'b1;
        if (stat.key_neg || stat.miss) begin
          cmd.res_ld = 1'b1;
          state_next = S_FIN;
        end else if (stat.hit) begin
          cmd.set_sel = 1'b1;
          state_next = S_C_PRD;
        end
      end
      S_C_PRD: begin
        cmd.slot_addr = SA_SEL;
        state_next = S_C_PDEC;
      end
      S_C_PDEC: begin
        cmd.pend_op = PEND_DEC;
        cmd.res_ld = 1'b1;
        state_next = S_FIN;
      end
      S_F_Q: begin
        if (!stat.q_more) begin
          cmd.res_ld = 1'b1;
          cmd.res_status = ST_NONE;
          state_next = S_FIN;
        end else begin
          state_next = S_F_E;
        end
      end
      S_F_E: begin
        cmd.slot_addr = SA_QDATA;
        cmd.ent_ld = 1'b1;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (stat.pend_one) begin
          cmd.key_ld = 1'b1;
          cmd.key_sel = KEY_DEP;
          cmd.scan_start = 1'b1;
          state_next = S_F_DEP;
        end else begin
          cmd.qptr_inc = 1'b1;
          state_next = S_F_Q;
        end
      end
      // a live dependency blocks this entry
      S_F_DEP: begin
        cmd.scan_step = 1'b1;
        if (stat.key_neg || stat.miss) begin
          state_next = S_F_R;
        end else if (stat.hit) begin
          cmd.qptr_inc = 1'b1;
          state_next = S_F_Q;
        end
      end
      S_F_R: begin
        cmd.slot_addr = SA_ENT;
        state_next = S_F_RES;
      end
      S_F_RES: begin
        cmd.res_ld = 1'b1;
        cmd.res_kind = RES_FETCH;
        state_next = S_F_SH;
      end
      // close the gap one entry at a time
      S_F_SH: begin
        if (stat.q_next_more) begin
          cmd.q_rd_next = 1'b1;
          state_next = S_F_SHW;
        end else begin
          cmd.q_dec = 1'b1;
          state_next = S_FIN;
        end
      end
      S_F_SHW: begin
        cmd.q_wr = 1'b1;
        cmd.qptr_inc = 1'b1;
        state_next = S_F_SH;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/dts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_dp
// Task table memories, ready queue, scan counter and the result register.
// ----------------------------------------------------------------------------
module dts_dp #(
  parameter int TASK_SLOTS  = 64,
  parameter int ID_LIMIT    = 65535,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [71:0]       s_tdata,
  input  logic [2:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [55:0]       m_tdata,
  output logic [2:0]        m_tuser,
  input  dts_pkg::dts_cmd_t  cmd,
  output dts_pkg::dts_stat_t stat
);
  import dts_pkg::*;

  localparam int SW  = $clog2(TASK_SLOTS);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int PW  = $clog2(TASK_SLOTS + 1);
  localparam int IDW = $clog2(ID_LIMIT + 1);
  localparam int CW  = (IDW > 16) ? IDW : 16;
  localparam int RW  = (IDW > 17) ? IDW : 17;

  logic [2:0]        act;
  logic [16:0]       tgt, rel, key;
  logic [31:0]       hdl;
  logic [SW:0]       scnt;
  logic              rd_v;
  logic [SW-1:0]     rd_idx, sel, ent;
  logic [QW:0]       qptr, qcount, qptr_p1;
  logic [IDW-1:0]    next_id;
  logic [TASK_SLOTS-1:0] live, pvalid;

  logic [IDW-1:0] tid_mem  [TASK_SLOTS];
  logic [16:0]    par_mem  [TASK_SLOTS];
  logic [16:0]    dep_mem  [TASK_SLOTS];
  logic [31:0]    work_mem [TASK_SLOTS];
  logic [PW-1:0]  pend_mem [TASK_SLOTS];
  logic [SW-1:0]  q_mem    [QUEUE_DEPTH];

  logic [IDW-1:0] tid_q;
  logic [16:0]    par_q, dep_q;
  logic [31:0]    work_q;
  logic [PW-1:0]  pend_raw, pend_q, pend_wr;
  logic           pv_q;
  logic [SW-1:0]  q_q, slot_ra;
  logic [QW-1:0]  q_ra, q_wa;
  logic [SW-1:0]  q_wd;
  logic           id_match;
  logic [RW-1:0]  tid_w, nid_w;

  logic [16:0] rid;
  logic [31:0] rwork;
  logic [2:0]  rstat;

  assign qptr_p1 = qptr + (QW+1)'(1);
  assign pend_q  = pv_q ? pend_raw : '0;
  assign tid_w   = RW'(tid_q);
  assign nid_w   = RW'(next_id);

  always_comb begin
    case (cmd.slot_addr)
      SA_SEL:   slot_ra = sel;
      SA_ENT:   slot_ra = ent;
      SA_QDATA: slot_ra = q_q;
      default:  slot_ra = scnt[SW-1:0];
    endcase
  end

  always_comb begin
    q_ra = cmd.q_rd_next ? qptr_p1[QW-1:0] : qptr[QW-1:0];
    q_wa = cmd.q_push ? qcount[QW-1:0] : qptr[QW-1:0];
    q_wd = cmd.q_push ? sel : q_q;
  end

  always_comb begin
    pend_wr = pend_q;
    case (cmd.pend_op)
      PEND_INC: if (pend_q < PW'(TASK_SLOTS)) pend_wr = pend_q + PW'(1);
      PEND_DEC: if (pend_q != '0) pend_wr = pend_q - PW'(1);
      default:  pend_wr = pend_q;
    endcase
  end

  assign id_match = live[rd_idx] && (CW'(tid_q) == CW'(key[15:0]));

  always_comb begin
    stat.act         = act;
    stat.hit         = rd_v && (cmd.scan_free ? (pend_q == '0) : id_match);
    stat.miss        = !rd_v && (scnt == (SW+1)'(TASK_SLOTS));
    stat.key_neg     = key[16];
    stat.pend_one    = (pend_q == PW'(1));
    stat.q_more      = (qptr < qcount);
    stat.q_next_more = (qptr_p1 < qcount);
    stat.q_full      = (qcount == (QW+1)'(QUEUE_DEPTH));
    stat.out_free    = !m_tvalid || m_tready;
  end

  // table and queue storage
  always_ff @(posedge clk) begin
    tid_q    <= tid_mem[slot_ra];
    par_q    <= par_mem[slot_ra];
    dep_q    <= dep_mem[slot_ra];
    work_q   <= work_mem[slot_ra];
    pend_raw <= pend_mem[slot_ra];
    pv_q     <= pvalid[slot_ra];
    q_q      <= q_mem[q_ra];
    if (cmd.alloc) begin
      tid_mem[sel]  <= next_id;
      par_mem[sel]  <= rel;
      work_mem[sel] <= hdl;
    end
    if (cmd.alloc) begin
      dep_mem[sel] <= '1;
    end else if (cmd.dep_wr) begin
      dep_mem[sel] <= rel;
    end
    if (cmd.alloc) begin
      pend_mem[sel] <= PW'(1);
    end else if (cmd.pend_op != PEND_NONE) begin
      pend_mem[sel] <= pend_wr;
    end
    if (cmd.q_push || cmd.q_wr) begin
      q_mem[q_wa] <= q_wd;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act <= s_tuser;
      tgt <= s_tdata[16:0];
      rel <= s_tdata[33:17];
      hdl <= s_tdata[65:34];
    end
    if (cmd.key_ld) begin
      case (cmd.key_sel)
        KEY_TGT: key <= tgt;
        KEY_DEP: key <= dep_q;
        KEY_PAR: key <= par_q;
        default: key <= rel;
      endcase
    end
    if (cmd.set_sel) sel <= rd_idx;
    if (cmd.ent_ld) ent <= q_q;
    if (cmd.res_ld) begin
      rstat <= cmd.res_status;
      case (cmd.res_kind)
        RES_NEWID: begin
          rid   <= nid_w[16:0];
          rwork <= '0;
        end
        RES_FETCH: begin
          rid   <= live[ent] ? tid_w[16:0] : '1;
          rwork <= work_q;
        end
        default: begin
          rid   <= '1;
          rwork <= '0;
        end
      endcase
    end
    if (cmd.out_ld) begin
      m_tdata <= {7'd0, rwork, rid};
      m_tuser <= rstat;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      pvalid   <= '0;
      qcount   <= '0;
      qptr     <= '0;
      next_id  <= '0;
      scnt     <= '0;
      rd_v     <= 1'b0;
      rd_idx   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.alloc) live[sel] <= 1'b1;
      if (cmd.kill) live[sel] <= 1'b0;
      if (cmd.alloc || cmd.pend_op != PEND_NONE) pvalid[sel] <= 1'b1;
      if (cmd.alloc) begin
        next_id <= (next_id == IDW'(ID_LIMIT)) ? '0 : next_id + IDW'(1);
      end
      if (cmd.q_push) begin
        qcount <= qcount + (QW+1)'(1);
      end else if (cmd.q_dec) begin
        qcount <= qcount - (QW+1)'(1);
      end
      if (cmd.qptr_clr) begin
        qptr <= '0;
      end else if (cmd.qptr_inc) begin
        qptr <= qptr_p1;
      end
      // one slot read per cycle; the compare sees the slot addressed in the cycle before
      if (cmd.scan_start) begin
        scnt <= '0;
        rd_v <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_v   <= (scnt < (SW+1)'(TASK_SLOTS));
        rd_idx <= scnt[SW-1:0];
        if (scnt < (SW+1)'(TASK_SLOTS)) scnt <= scnt + (SW+1)'(1);
      end
      if (cmd.out_ld) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> tb/tb_dependency_task_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dependency_task_scheduler_core
// Drives add, depend, queue, fetch and complete beats into the scheduler and
// checks every result beat against a cycle-free task table model kept here.
// A short directed table comes first, then random phases with different mixes.
// ----------------------------------------------------------------------------
module tb_dependency_task_scheduler_core;
  import dts_pkg::*;

  localparam int SLOTS = 64;
  localparam int IDMAX = 65535;
  localparam int QDEPTH = 64;
  localparam int N_RANDOM = 1930;

  typedef struct {
    logic signed [16:0] id;
    logic [31:0]        work;
    logic [2:0]         status;
  } sched_result_t;

  typedef struct {
    logic [2:0]  act;
    int          tgt;
    int          rel;
    logic [31:0] work;
    bit          typed;
    int          eid;
    logic [31:0] ework;
    logic [2:0]  est;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;

  dependency_task_scheduler_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // task table mirror
  bit          t_live[SLOTS];
  logic [15:0] t_id[SLOTS];
  int          t_pend[SLOTS];
  int          t_par[SLOTS];
  int          t_dep[SLOTS];
  logic [31:0] t_work[SLOTS];
  int          ready_fifo[$];
  int          id_counter;

  sched_result_t pending_results[$];
  dir_row_t      dir_rows[$];
  int            issued_ids[$];
  int            errors = 0;
  int            mismatches = 0;
  bit            quiet = 1'b0;
  bit            long_hold_req = 1'b0;

  function automatic int slot_of(int id);
    if (id < 0) return -1;
    for (int i = 0; i < SLOTS; i++)
      if (t_live[i] && t_id[i] == id[15:0] && id <= IDMAX) return i;
    return -1;
  endfunction

  function automatic void bump(int s, int d);
    if (s < 0) return;
    if (d > 0 && t_pend[s] < SLOTS) t_pend[s]++;
    if (d < 0 && t_pend[s] > 0) t_pend[s]--;
  endfunction

  function automatic sched_result_t schedule_step(logic [2:0] act, int tgt, int rel,
                                                  logic [31:0] h);
    sched_result_t r;
    int s;
    int e;
    r.id = -17'sd1;
    r.work = '0;
    r.status = ST_OK;
    case (act)
      ACT_ADD: begin
        bump(slot_of(rel), 1);
        r.status = ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (t_pend[i] == 0) begin
            t_live[i] = 1'b1;
            t_id[i] = id_counter[15:0];
            t_pend[i] = 1;
            t_par[i] = rel;
            t_dep[i] = -1;
            t_work[i] = h;
            r.id = 17'(id_counter);
            id_counter = (id_counter >= IDMAX) ? 0 : id_counter + 1;
            r.status = ST_OK;
            break;
          end
        end
      end
      ACT_DEPEND: begin
        s = slot_of(tgt);
        if (s < 0) r.status = ST_UNKNOWN;
        else t_dep[s] = rel;
      end
      ACT_QUEUE: begin
        s = slot_of(tgt);
        if (s < 0) r.status = ST_UNKNOWN;
        else if (ready_fifo.size() >= QDEPTH) r.status = ST_QFULL;
        else ready_fifo.push_back(s);
      end
      ACT_FETCH: begin
        r.status = ST_NONE;
        for (int q = 0; q < ready_fifo.size(); q++) begin
          e = ready_fifo[q];
          if (t_pend[e] == 1 && slot_of(t_dep[e]) < 0) begin
            r.id = t_live[e] ? {1'b0, t_id[e]} : -17'sd1;
            r.work = t_work[e];
            ready_fifo.delete(q);
            r.status = ST_OK;
            break;
          end
        end
      end
      ACT_COMPLETE: begin
        s = slot_of(tgt);
        if (s < 0) r.status = ST_UNKNOWN;
        else begin
          bump(s, -1);
          t_live[s] = 1'b0;
          bump(slot_of(t_par[s]), -1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one beat, with an optional idle burst first; returns at a falling edge.
  task automatic send_beat(logic [2:0] act, int tgt, int rel, logic [31:0] h,
                           bit typed, sched_result_t typed_res);
    sched_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = {6'b0, h, rel[16:0], tgt[16:0]};
    do @(posedge clk); while (!s_tready);
    r = schedule_step(act, tgt, rel, h);
    pending_results.push_back(typed ? typed_res : r);
    if (act == ACT_ADD && r.status == ST_OK) begin
      issued_ids.push_back(int'(r.id));
      if (issued_ids.size() > 96) void'(issued_ids.pop_front());
    end
    @(negedge clk);
  endtask

  task automatic row(logic [2:0] act, int tgt, int rel, logic [31:0] h, bit typed,
                     int eid, logic [31:0] ew, logic [2:0] est);
    dir_row_t d;
    d = '{act, tgt, rel, h, typed, eid, ew, est};
    dir_rows.push_back(d);
  endtask

  function automatic int pick_id();
    int k;
    k = $urandom_range(0, 99);
    if (k < 72 && issued_ids.size() > 0)
      return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
    if (k < 82) return -1;
    if (k < 92) return int'($signed(17'($urandom)));
    return $urandom_range(0, 80);
  endfunction

  // receiver: random stalls, one long hold-off on request
  int stall_left = 0;
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result beat %h/%h", m_tdata, m_tuser);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[16:0] !== exp_r.id || m_tdata[48:17] !== exp_r.work
            || m_tuser !== exp_r.status) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp id %0d work %h st %0d, got id %0d work %h st %0d",
                     exp_r.id, exp_r.work, exp_r.status, $signed(m_tdata[16:0]),
                     m_tdata[48:17], m_tuser);
        end
      end
    end
  end

  initial begin
    #(400_000_000);
    $display("tb_dependency_task_scheduler_core NOT OK");
    $finish;
  end

  initial begin
    sched_result_t tr;
    dir_row_t d;
    int mode;
    int k;
    int fixed_parent;
    logic [2:0] act;
    int tgt;
    int rel;
    logic [31:0] h;
    id_counter = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    row(ACT_FETCH, -1, -1, 32'h0, 1, -1, 0, ST_NONE);
    row(ACT_DEPEND, 5, 0, 32'h0, 1, -1, 0, ST_UNKNOWN);
    row(ACT_QUEUE, -1, -1, 32'h0, 1, -1, 0, ST_UNKNOWN);
    row(ACT_COMPLETE, 65535, -1, 32'h0, 1, -1, 0, ST_UNKNOWN);
    row(ACT_ADD, -1, -1, 32'hFFFF_FFFF, 1, 0, 0, ST_OK);
    row(ACT_ADD, -1, 0, 32'h0, 1, 1, 0, ST_OK);
    row(ACT_QUEUE, 0, -1, 32'h0, 0, 0, 0, ST_OK);
    row(ACT_QUEUE, 1, -1, 32'h0, 0, 0, 0, ST_OK);
    row(ACT_FETCH, -1, -1, 32'h0, 0, 0, 0, ST_OK);
    row(ACT_DEPEND, 0, 1, 32'h0, 0, 0, 0, ST_OK);
    row(ACT_QUEUE, 0, -1, 32'h0, 0, 0, 0, ST_OK);
    row(ACT_FETCH, -1, -1, 32'h0, 0, 0, 0, ST_OK);
    row(ACT_COMPLETE, 1, -1, 32'h0, 0, 0, 0, ST_OK);
    row(ACT_FETCH, -1, -1, 32'h0, 0, 0, 0, ST_OK);
    row(3'd5, 65535, 65535, 32'hFFFF_FFFF, 1, -1, 0, ST_OK);
    row(3'd7, -65536, -65536, 32'h0, 1, -1, 0, ST_OK);
    row(ACT_ADD, -1, -65536, 32'h5A5A_5A5A, 0, 0, 0, ST_OK);
    row(ACT_ADD, -1, 2, 32'hA5A5_A5A5, 0, 0, 0, ST_OK);
    row(ACT_QUEUE, 2, -1, 32'h0, 0, 0, 0, ST_OK);
    // parent retired while a child holds it, then a fetch
    row(ACT_COMPLETE, 2, -1, 32'h0, 0, 0, 0, ST_OK);
    row(ACT_FETCH, -1, -1, 32'h0, 0, 0, 0, ST_OK);
    row(ACT_DEPEND, 65535, 65535, 32'h0, 1, -1, 0, ST_UNKNOWN);

    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      tr.id = 17'(d.eid);
      tr.work = d.ework;
      tr.status = d.est;
      send_beat(d.act, d.tgt, d.rel, d.work, d.typed, tr);
    end

    mode = 0;
    fixed_parent = -1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 120 == 0) begin
        mode = $urandom_range(0, 3);
        fixed_parent = pick_id();
      end
      if (n == 600) long_hold_req = 1'b1;
      if (n == N_RANDOM - 250) quiet = 1'b1;
      k = $urandom_range(0, 99);
      case (mode)
        1: act = (k < 70) ? ACT_ADD : (k < 80) ? ACT_QUEUE : (k < 90) ? ACT_FETCH
               : ACT_DEPEND;
        2: act = (k < 15) ? ACT_ADD : (k < 65) ? ACT_QUEUE : (k < 80) ? ACT_FETCH
               : (k < 90) ? ACT_DEPEND : ACT_COMPLETE;
        3: act = (k < 15) ? ACT_ADD : (k < 25) ? ACT_QUEUE : (k < 45) ? ACT_FETCH
               : (k < 55) ? ACT_DEPEND : ACT_COMPLETE;
        default: act = (k < 25) ? ACT_ADD : (k < 45) ? ACT_QUEUE : (k < 65) ? ACT_FETCH
                     : (k < 80) ? ACT_DEPEND : ACT_COMPLETE;
      endcase
      if ($urandom_range(0, 59) == 0) act = 3'($urandom_range(5, 7));
      tgt = pick_id();
      rel = pick_id();
      // steady parent in add-heavy stretches drives pending counts to saturation
      if (act == ACT_ADD && mode == 1 && $urandom_range(0, 1) == 0) rel = fixed_parent;
      h = $urandom;
      send_beat(act, tgt, rel, h, 0, tr);
    end
    s_tvalid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_dependency_task_scheduler_core OK");
    end else begin
      $display("tb_dependency_task_scheduler_core NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
design/dts_pkg.sv
design/dts_ctrl.sv
design/dts_dp.sv
design/dependency_task_scheduler_core.sv
tb/tb_dependency_task_scheduler_core.sv
